### src/cltz_pkg.sv
`default_nettype none

package cltz_pkg;

  localparam int TABLE_DEPTH_DEF = 65536;
  localparam int PATH_DEPTH_DEF  = 16384;

  localparam int START_W   = 16;
  localparam int OUTCOME_W = 2;
  localparam int STEPS_W   = 15;

  // memo marks
  localparam logic [1:0] MARK_UNKNOWN = 2'd0;
  localparam logic [1:0] MARK_ONE     = 2'd1;
  localparam logic [1:0] MARK_CYCLE   = 2'd2;
  localparam logic [1:0] MARK_PATH    = 2'd3;

  // result outcome codes
  localparam logic [OUTCOME_W-1:0] OUT_ONE     = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUT_CYCLE   = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUT_UNKNOWN = 2'd2;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic               beyond;
  } cltz_job_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_WB,
    ST_DONE
  } cltz_state_t;

endpackage

`default_nettype wire

### src/cltz_ram.sv
`default_nettype none

module cltz_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### src/cltz_front.sv
`default_nettype none

module cltz_front #(
  parameter int TABLE_DEPTH = cltz_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         hold,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [cltz_pkg::START_W-1:0] in_start,
  output logic                              job_valid,
  input  wire logic                         job_ready,
  output cltz_pkg::cltz_job_t               job
);

  cltz_pkg::cltz_job_t entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;
  cltz_pkg::cltz_job_t incoming;

  assign in_ready  = (count != 2'd2) && !hold;
  assign job_valid = (count != 2'd0);
  assign job       = entry[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = job_valid && job_ready;

  // starts outside the table skip the walk entirely
  always_comb begin
    incoming.start  = in_start;
    incoming.beyond = (32'(in_start) >= 32'(TABLE_DEPTH));
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

### src/cltz_walker.sv
`default_nettype none

module cltz_walker #(
  parameter int TABLE_DEPTH = cltz_pkg::TABLE_DEPTH_DEF,
  parameter int PATH_DEPTH  = cltz_pkg::PATH_DEPTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  output logic                                clearing,
  input  wire logic                           job_valid,
  output logic                                job_ready,
  input  wire cltz_pkg::cltz_job_t            job,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [cltz_pkg::OUTCOME_W-1:0]      out_outcome,
  output logic [cltz_pkg::STEPS_W-1:0]        out_steps
);

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int VW  = ((AW > cltz_pkg::START_W) ? AW : cltz_pkg::START_W) + 2;
  localparam int PIW = (PATH_DEPTH > 1) ? $clog2(PATH_DEPTH) : 1;
  localparam int PLW = $clog2(PATH_DEPTH + 1);

  cltz_pkg::cltz_state_t state, state_next;

  logic [AW-1:0]  clr_cnt;
  logic [VW-1:0]  v;
  logic [PLW-1:0] len;
  logic [PLW-1:0] wb_idx;
  logic           rd_pend;
  logic [1:0]     found;
  logic           stopped;

  logic           memo_we;
  logic [AW-1:0]  memo_waddr;
  logic [1:0]     memo_wdata;
  logic           memo_re;
  logic [1:0]     memo_rdata;
  logic           path_we;
  logic           path_re;
  logic [AW-1:0]  path_rdata;
  logic           load_out;

  logic           v_beyond;
  logic [VW-1:0]  v_step;
  logic [PLW-1:0] len_inc;
  logic           path_full;
  logic [1:0]     fin;
  logic [PLW:0]   steps_full;
  logic [PLW+15:0] steps_wide;

  assign v_beyond  = (v >= VW'(TABLE_DEPTH));
  // even halves, odd goes to 3n-1
  assign v_step    = v[0] ? ((v << 1) + v - VW'(1)) : (v >> 1);
  assign len_inc   = len + PLW'(1);
  assign path_full = (len_inc >= PLW'(PATH_DEPTH));

  always_comb begin
    if (stopped) begin
      fin = cltz_pkg::MARK_UNKNOWN;
    end else if (found == cltz_pkg::MARK_PATH) begin
      fin = cltz_pkg::MARK_CYCLE;
    end else begin
      fin = found;
    end
  end

  assign steps_full = {1'b0, len} + (PLW + 1)'(1);
  assign steps_wide = {15'b0, steps_full};

  assign clearing = (state == cltz_pkg::ST_CLEAR);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      cltz_pkg::ST_CLEAR: begin
        if (clr_cnt == AW'(TABLE_DEPTH - 1)) begin
          state_next = cltz_pkg::ST_IDLE;
        end
      end
      cltz_pkg::ST_IDLE: begin
        if (job_valid) begin
          state_next = job.beyond ? cltz_pkg::ST_WB : cltz_pkg::ST_READ;
        end
      end
      cltz_pkg::ST_READ: begin
        state_next = v_beyond ? cltz_pkg::ST_WB : cltz_pkg::ST_CHECK;
      end
      cltz_pkg::ST_CHECK: begin
        if (memo_rdata != cltz_pkg::MARK_UNKNOWN || path_full) begin
          state_next = cltz_pkg::ST_WB;
        end else begin
          state_next = cltz_pkg::ST_READ;
        end
      end
      cltz_pkg::ST_WB: begin
        if (wb_idx == len && !rd_pend) begin
          state_next = cltz_pkg::ST_DONE;
        end
      end
      cltz_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = cltz_pkg::ST_IDLE;
        end
      end
      default: state_next = cltz_pkg::ST_CLEAR;
    endcase
  end

  // memory and handshake controls
  always_comb begin
    memo_we    = 1'b0;
    memo_waddr = v[AW-1:0];
    memo_wdata = cltz_pkg::MARK_PATH;
    memo_re    = 1'b0;
    path_we    = 1'b0;
    path_re    = 1'b0;
    job_ready  = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      cltz_pkg::ST_CLEAR: begin
        memo_we    = 1'b1;
        memo_waddr = clr_cnt;
        memo_wdata = (clr_cnt < AW'(2)) ? cltz_pkg::MARK_ONE : cltz_pkg::MARK_UNKNOWN;
      end
      cltz_pkg::ST_IDLE: begin
        job_ready = 1'b1;
      end
      cltz_pkg::ST_READ: begin
        memo_re = !v_beyond;
      end
      cltz_pkg::ST_CHECK: begin
        if (memo_rdata == cltz_pkg::MARK_UNKNOWN) begin
          memo_we = 1'b1;
          path_we = 1'b1;
        end
      end
      cltz_pkg::ST_WB: begin
        path_re    = (wb_idx != len);
        memo_we    = rd_pend;
        memo_waddr = path_rdata;
        memo_wdata = fin;
      end
      cltz_pkg::ST_DONE: begin
        load_out = !out_valid || out_ready;
      end
      default: begin
      end
    endcase
  end

  cltz_ram #(.WIDTH(2), .DEPTH(TABLE_DEPTH)) u_memo (
    .clk   (clk),
    .we    (memo_we),
    .waddr (memo_waddr),
    .wdata (memo_wdata),
    .re    (memo_re),
    .raddr (v[AW-1:0]),
    .rdata (memo_rdata)
  );

  cltz_ram #(.WIDTH(AW), .DEPTH(PATH_DEPTH)) u_path (
    .clk   (clk),
    .we    (path_we),
    .waddr (len[PIW-1:0]),
    .wdata (v[AW-1:0]),
    .re    (path_re),
    .raddr (wb_idx[PIW-1:0]),
    .rdata (path_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cltz_pkg::ST_CLEAR;
      clr_cnt   <= '0;
      rd_pend   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == cltz_pkg::ST_CLEAR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      if (state == cltz_pkg::ST_WB) begin
        rd_pend <= (wb_idx != len);
      end else begin
        rd_pend <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      cltz_pkg::ST_IDLE: begin
        v       <= VW'(job.start);
        len     <= '0;
        wb_idx  <= '0;
        found   <= cltz_pkg::MARK_UNKNOWN;
        stopped <= job.beyond;
      end
      cltz_pkg::ST_READ: begin
        if (v_beyond) begin
          stopped <= 1'b1;
        end
      end
      cltz_pkg::ST_CHECK: begin
        if (memo_rdata != cltz_pkg::MARK_UNKNOWN) begin
          found <= memo_rdata;
        end else begin
          len <= len_inc;
          v   <= v_step;
          if (path_full) begin
            stopped <= 1'b1;
          end
        end
      end
      cltz_pkg::ST_WB: begin
        if (wb_idx != len) begin
          wb_idx <= wb_idx + PLW'(1);
        end
      end
      default: begin
      end
    endcase
    if (load_out) begin
      if (fin == cltz_pkg::MARK_ONE) begin
        out_outcome <= cltz_pkg::OUT_ONE;
        out_steps   <= steps_wide[14:0];
      end else if (fin == cltz_pkg::MARK_CYCLE) begin
        out_outcome <= cltz_pkg::OUT_CYCLE;
        out_steps   <= '0;
      end else begin
        out_outcome <= cltz_pkg::OUT_UNKNOWN;
        out_steps   <= '0;
      end
    end
  end

endmodule

`default_nettype wire

### src/collatz_3n_minus_1_classifier.sv
// channel  | direction | tdata bits, lowest first
// s_axis   | in        | [15:0] start_value
// m_axis   | out       | [1:0] outcome, [16:2] new_steps, [23:17] zero
//
// each newly walked value takes a memo read and a path mark until the walk stops on a
// marked value, on leaving the table or on a full path store; the outcome is then
// written back to every stored path value; taking the job comes before the walk and
// loading the result comes after the write-back
// a clearing pass fills the memo after reset, no word taken until done
// a two-entry queue takes input words while a walk runs; a finished result waits in
// the output register until taken, and the walker holds its next result until then
`default_nettype none

module collatz_3n_minus_1_classifier #(
  parameter int TABLE_DEPTH = cltz_pkg::TABLE_DEPTH_DEF,
  parameter int PATH_DEPTH  = cltz_pkg::PATH_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // [15:0] start_value
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata   // [1:0] outcome, [16:2] new_steps
);

  logic                                 clearing;
  logic                                 job_valid;
  logic                                 job_ready;
  cltz_pkg::cltz_job_t                  job;
  logic [cltz_pkg::OUTCOME_W-1:0]       outcome;
  logic [cltz_pkg::STEPS_W-1:0]         new_steps;

  cltz_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .hold      (clearing),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_start  (s_axis_tdata),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  cltz_walker #(.TABLE_DEPTH(TABLE_DEPTH), .PATH_DEPTH(PATH_DEPTH)) u_walker (
    .clk         (clk),
    .rst         (rst),
    .clearing    (clearing),
    .job_valid   (job_valid),
    .job_ready   (job_ready),
    .job         (job),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_outcome (outcome),
    .out_steps   (new_steps)
  );

  assign m_axis_tdata = {7'b0, new_steps, outcome};

`ifndef SYNTHESIS
  a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_axis_tready)
    else $error("input accepted during memo clear");

  a_no_job_while_clearing: assert property (@(posedge clk) disable iff (rst)
    (job_valid && job_ready) |-> !clearing)
    else $error("walker took a job during memo clear");

  a_steps_only_on_one: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && outcome != cltz_pkg::OUT_ONE) |-> (new_steps == '0))
    else $error("step count on a result that does not reach one");

  a_outcome_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (outcome <= cltz_pkg::OUT_UNKNOWN))
    else $error("invalid outcome code");
`endif

endmodule

`default_nettype wire
